// ===== rtl/core/risd_pkg.sv =====
// ----------------------------------------------------------------------------
// risd_pkg: shared types for the record insertion sorter
// Record layout, the link that one cell hands to its neighbor, and the
// control word that steers every cell of the chain.
// ----------------------------------------------------------------------------
package risd_pkg;

  localparam int AgeW    = 8;
  localparam int NameLoW = 64;
  localparam int NameMiW = 64;
  localparam int NameHiW = 32;

  // One person record
  typedef struct packed {
    logic [AgeW-1:0]    age;
    logic [NameLoW-1:0] name_low;
    logic [NameMiW-1:0] name_mid;
    logic [NameHiW-1:0] name_high;
  } rec_t;

  // Contents of one cell as seen by its neighbors
  typedef struct packed {
    logic valid;
    rec_t rec;
  } link_t;

  // Chain-wide control, one per cycle
  typedef struct packed {
    logic insert;     // place the broadcast record into the chain
    logic shift_out;  // move every cell one place toward the head
  } ctl_t;

endpackage

// ===== rtl/core/risd_if.sv =====
// ----------------------------------------------------------------------------
// risd_if: request channels of the record insertion sorter
// Input record channel and sorted result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface risd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  age;
  logic [63:0] name_low;
  logic [63:0] name_mid;
  logic [31:0] name_high;
  logic        last_record;

  modport source (output valid, age, name_low, name_mid, name_high, last_record,
                  input ready);
  modport sink   (input valid, age, name_low, name_mid, name_high, last_record,
                  output ready);
endinterface

interface risd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  sorted_age;
  logic [63:0] sorted_name_low;
  logic [63:0] sorted_name_mid;
  logic [31:0] sorted_name_high;
  logic        end_of_list;
  logic        overflowed;

  modport source (output valid, sorted_age, sorted_name_low, sorted_name_mid,
                  sorted_name_high, end_of_list, overflowed,
                  input ready);
  modport sink   (input valid, sorted_age, sorted_name_low, sorted_name_mid,
                  sorted_name_high, end_of_list, overflowed,
                  output ready);
endinterface

// ===== rtl/core/risd_cell.sv =====
// ----------------------------------------------------------------------------
// risd_cell: one slot of the sorting chain
// Holds one record. On insert it keeps its record, takes the new one, or
// takes its upper neighbor's; on drain it takes its lower neighbor's.
// ----------------------------------------------------------------------------
module risd_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  risd_pkg::ctl_t ctl,
  input  risd_pkg::rec_t new_rec,
  input  logic           prev_ge,
  input  risd_pkg::link_t prev_link,
  input  risd_pkg::link_t next_link,
  output risd_pkg::link_t link,
  output logic           ge
);

  logic           valid_r, valid_nxt;
  risd_pkg::rec_t rec_r, rec_nxt;

  // Equal keys stay ahead of the new record, which keeps the sort stable
  assign ge   = valid_r && (rec_r.age >= new_rec.age);
  assign link = '{valid: valid_r, rec: rec_r};

  // Pick the next contents of the slot
  always_comb begin
    valid_nxt = valid_r;
    rec_nxt   = rec_r;
    if (ctl.shift_out) begin
      valid_nxt = next_link.valid;
      rec_nxt   = next_link.rec;
    end else if (ctl.insert && !ge) begin
      if (prev_ge) begin
        valid_nxt = 1'b1;
        rec_nxt   = new_rec;
      end else begin
        valid_nxt = prev_link.valid;
        rec_nxt   = prev_link.rec;
      end
    end
  end

  // Clear the occupancy bit on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold or load the record
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// ===== rtl/core/record_insertion_sort_desc_core.sv =====
// ----------------------------------------------------------------------------
// record_insertion_sort_desc_core: stable descending insertion sorter
// Sorts person records by age, largest first, in a chain of cells and
// streams the sorted set out when the last record of a set arrives.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    age, name_low/mid/high, last_record
//   out_ch    source     valid/ready    sorted_age, sorted_name_*, end_of_list,
//                                       overflowed
//
// Loading takes one record per cycle: every cell compares its key with the
// broadcast record in parallel and the chain shifts in a single step.
// After a record marked last, the chain drains one result per cycle from
// its head while out_ch.ready is high; in_ch.ready is low for the whole
// drain. A stalled result holds in the head cell. Reset empties the chain
// and clears the overflow flag at once. Records that arrive with all
// CAPACITY cells full are dropped.
// ----------------------------------------------------------------------------
module record_insertion_sort_desc_core #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  risd_in_if.sink    in_ch,
  risd_out_if.source out_ch
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic state_r, state_nxt;
  logic dropped_r, dropped_nxt;

  risd_pkg::ctl_t  ctl;
  risd_pkg::rec_t  new_rec;
  risd_pkg::link_t links     [CAPACITY];
  risd_pkg::link_t prev_link [CAPACITY];
  risd_pkg::link_t next_link [CAPACITY];
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] prev_ge;
  logic [CAPACITY-1:0] valid_vec;

  logic in_fire, out_fire, full, end_flag;

  // Broadcast record
  assign new_rec = '{age: in_ch.age, name_low: in_ch.name_low,
                     name_mid: in_ch.name_mid, name_high: in_ch.name_high};

  assign full     = valid_vec[CAPACITY-1];
  assign end_flag = !valid_vec[1];

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign ctl.insert    = in_fire && !full;
  assign ctl.shift_out = out_fire;

  // Wire neighbors; the head sees an always-greater predecessor
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = links[i].valid;
      if (i == 0) begin
        prev_ge[i]   = 1'b1;
        prev_link[i] = links[i];
      end else begin
        prev_ge[i]   = ge_vec[i-1];
        prev_link[i] = links[i-1];
      end
      if (i == CAPACITY-1) begin
        next_link[i] = '{valid: 1'b0, rec: links[i].rec};
      end else begin
        next_link[i] = links[i+1];
      end
    end
  end

  // Chain of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    risd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_rec   (new_rec),
      .prev_ge   (prev_ge[g]),
      .prev_link (prev_link[g]),
      .next_link (next_link[g]),
      .link      (links[g]),
      .ge        (ge_vec[g])
    );
  end

  // Head cell drives the result channel
  assign out_ch.valid            = (state_r == ST_DRAIN);
  assign out_ch.sorted_age       = links[0].rec.age;
  assign out_ch.sorted_name_low  = links[0].rec.name_low;
  assign out_ch.sorted_name_mid  = links[0].rec.name_mid;
  assign out_ch.sorted_name_high = links[0].rec.name_high;
  assign out_ch.end_of_list      = end_flag;
  assign out_ch.overflowed       = dropped_r;

  // Advance load/drain control and the drop flag
  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          dropped_nxt = dropped_r | full;
          if (in_ch.last_record) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire && end_flag) begin
          state_nxt   = ST_LOAD;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Occupied cells always form an unbroken run from the head
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + {{(CAPACITY-1){1'b0}}, 1'b1})) == '0)
    else $error("sorter chain has a gap");

  // A drain always has a record at the head
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> valid_vec[0])
    else $error("drain with empty chain");

  // The final result leaves the chain empty and reopens the input
  a_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && end_flag) |=> (!valid_vec[0] && in_ch.ready && !dropped_r))
    else $error("chain not cleared after end of list");

endmodule
